// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the sieve rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/spps_pkg.sv =====
// types and constants of the smallest prime power sieve
`default_nettype none
package spps_pkg;
	localparam int QN_W   = 16;
	localparam int FAC_W  = 16;
	localparam int EXP_W  = 4;
	localparam int LIM_W  = 17;
	localparam int ADDR_W = 16;
	localparam int P_W    = 9;
	localparam int FULL_DEPTH = 1 << ADDR_W;
	localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(FULL_DEPTH);

	typedef struct packed {
		logic             comp;
		logic [FAC_W-1:0] factor;
		logic [FAC_W-1:0] power;
		logic [EXP_W-1:0] expo;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/spps_query_if.sv =====
// query channel carrying the number to look up
`default_nettype none
interface spps_query_if
	import spps_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [QN_W-1:0] query_number;

	modport source(output valid, output query_number, input ready);
	modport sink(input valid, input query_number, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/spps_result_if.sv =====
// result channel carrying one table lookup
`default_nettype none
interface spps_result_if
	import spps_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             out_of_range;
	logic             is_prime;
	logic [FAC_W-1:0] smallest_factor;
	logic [FAC_W-1:0] factor_power;
	logic [EXP_W-1:0] multiplicity;

	modport source(output valid, output out_of_range, output is_prime,
		output smallest_factor, output factor_power, output multiplicity, input ready);
	modport sink(input valid, input out_of_range, input is_prime,
		input smallest_factor, input factor_power, input multiplicity, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/spps_mem.sv =====
// sieve table ram, one write and one registered read port
`default_nettype none
module spps_mem
	import spps_pkg::*;
#(
	parameter int DEPTH = 65536
) (
	input  wire logic     clk,
	input  wire mem_req_t req,
	output entry_t        rd_data
);
	localparam int AW = $clog2(DEPTH);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr[AW-1:0]];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/spps_sieve.sv =====
// table clear and eratosthenes build sequencer with read-modify-write
`default_nettype none
`include "assert_macros.svh"
module spps_sieve
	import spps_pkg::*;
#(
	parameter int DEPTH = 65536
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire entry_t rd_data,
	output mem_req_t    req,
	output logic        done
);
	localparam int AW = $clog2(DEPTH);
	localparam int KW = AW + 2;
	localparam logic [31:0] DEPTH_W = 32'(DEPTH);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_PRD    = 3'd1;
	localparam logic [2:0] S_PTEST  = 3'd2;
	localparam logic [2:0] S_POW    = 3'd3;
	localparam logic [2:0] S_STRIKE = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [P_W-1:0]    p_q;
	logic [ADDR_W-1:0] pw_q;
	logic [EXP_W-1:0]  e_q;
	logic [KW-1:0]     k_q;
	logic [ADDR_W-1:0] pow_q [1 << EXP_W];

	logic              s1_valid;
	logic              s1_strike;
	logic [ADDR_W-1:0] s1_addr;
	logic [P_W-1:0]    s1_p;
	logic [ADDR_W-1:0] s1_pw;
	logic [EXP_W-1:0]  s1_e;
	logic              fwd_s1;
	entry_t            fwd_word_s1;

	logic [2*P_W-1:0]      pp;
	logic [ADDR_W+P_W-1:0] prod;
	logic                  pp_in;
	logic                  prod_in;
	logic                  strike_rd;
	logic                  check_rd;
	logic                  strike_wr;
	entry_t                rd_word;
	entry_t                clr_word;

	assign pp        = p_q * p_q;
	assign prod      = pw_q * p_q;
	assign pp_in     = 32'(pp) < DEPTH_W;
	assign prod_in   = 32'(prod) < DEPTH_W;
	assign strike_rd = (state_q == S_STRIKE) && (32'(k_q) < DEPTH_W);
	assign check_rd  = (state_q == S_PRD) && pp_in;
	assign rd_word   = fwd_s1 ? fwd_word_s1 : rd_data;
	assign strike_wr = s1_valid && s1_strike && !rd_word.comp;
	assign done      = (state_q == S_DONE);

	// zero and one are marked with their fixed entries
	always_comb begin
		clr_word = '0;
		if (clr_q == AW'(0)) begin
			clr_word.comp = 1'b1;
		end else if (clr_q == AW'(1)) begin
			clr_word.comp   = 1'b1;
			clr_word.factor = FAC_W'(1);
			clr_word.power  = FAC_W'(1);
		end
	end

	always_comb begin
		req.rd_en   = check_rd || strike_rd;
		req.rd_addr = check_rd ? ADDR_W'(p_q) : ADDR_W'(k_q);
		req.wr_en   = (state_q == S_CLEAR) || strike_wr;
		if (state_q == S_CLEAR) begin
			req.wr_addr = ADDR_W'(clr_q);
			req.wr_data = clr_word;
		end else begin
			req.wr_addr        = s1_addr;
			req.wr_data.comp   = 1'b1;
			req.wr_data.factor = FAC_W'(s1_p);
			req.wr_data.power  = s1_pw;
			req.wr_data.expo   = s1_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			s1_strike <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			s1_valid  <= req.rd_en;
			s1_strike <= strike_rd;
			fwd_s1    <= req.wr_en && req.rd_en && (req.wr_addr == req.rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		s1_addr     <= req.rd_addr;
		s1_p        <= p_q;
		s1_pw       <= pw_q;
		s1_e        <= e_q;
		fwd_word_s1 <= req.wr_data;
		if (state_q == S_PTEST && !rd_word.comp) begin
			pow_q[EXP_W'(1)] <= ADDR_W'(p_q);
		end else if (state_q == S_POW && prod_in) begin
			pow_q[e_q + EXP_W'(1)] <= prod[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			p_q     <= P_W'(2);
			pw_q    <= '0;
			e_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_PRD;
					end
				end
				S_PRD: begin
					state_q <= pp_in ? S_PTEST : S_DONE;
				end
				S_PTEST: begin
					if (rd_word.comp) begin
						p_q     <= p_q + P_W'(1);
						state_q <= S_PRD;
					end else begin
						pw_q    <= ADDR_W'(p_q);
						e_q     <= EXP_W'(1);
						state_q <= S_POW;
					end
				end
				S_POW: begin
					if (prod_in) begin
						pw_q <= prod[ADDR_W-1:0];
						e_q  <= e_q + EXP_W'(1);
					end else begin
						k_q     <= KW'(pw_q);
						state_q <= S_STRIKE;
					end
				end
				S_STRIKE: begin
					// highest power first so an entry keeps its full power
					if (strike_rd) begin
						k_q <= k_q + KW'(pw_q);
					end else if (e_q == EXP_W'(1)) begin
						p_q     <= p_q + P_W'(1);
						state_q <= S_PRD;
					end else begin
						e_q  <= e_q - EXP_W'(1);
						pw_q <= pow_q[e_q - EXP_W'(1)];
						k_q  <= (e_q == EXP_W'(2)) ? KW'(pow_q[EXP_W'(2)]) : KW'(pow_q[e_q - EXP_W'(1)]);
					end
				end
				S_DONE: begin
					state_q <= S_DONE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	`ASSERT_IMPL(a_no_wr_done, state_q == S_DONE, !req.wr_en, "table written after build")
	`ASSERT_IMPL(a_ptest_read, state_q == S_PTEST, s1_valid && !s1_strike, "prime check without read")
	`ASSERT_IMPL(a_strike_exp, state_q == S_STRIKE, e_q != EXP_W'(0), "strike pass with zero exponent")
endmodule
`default_nettype wire

// ===== rtl/core/smallest_prime_power_sieve_core.sv =====
// smallest prime power sieve, top level with query path and limit register
// after reset the table ram is cleared (at most 65536 entries) and then sieved; the sieve
// visits each multiple of each prime below the square root once per power
// no query is taken until the build is done; writes of the limit do not rebuild the table
// a query reads the table ram and the entry is then registered into the result outputs;
// one query per cycle sustained while the result is taken, set by the single read port
// of the table ram
`default_nettype none
`include "assert_macros.svh"
module smallest_prime_power_sieve_core
	import spps_pkg::*;
#(
	parameter int TABLE_SIZE = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [LIM_W-1:0]  cfg_wr_data,
	spps_query_if.sink             query,
	spps_result_if.source          result
);
	localparam int MEM_DEPTH = (TABLE_SIZE < FULL_DEPTH) ? TABLE_SIZE : FULL_DEPTH;
	localparam logic [31:0] TABLE_W = 32'(TABLE_SIZE);

	logic [LIM_W-1:0] limit_q;
	logic             done;
	mem_req_t         sieve_req;
	mem_req_t         mem_req;
	entry_t           rd_data;

	logic            q_acc;
	logic            q_oor;
	logic            in_ready;
	logic            load_out;
	logic            q_s1;
	logic            oor_s1;
	logic [QN_W-1:0] n_s1;

	logic             out_valid_q;
	logic             oor_q;
	logic             prime_q;
	logic [FAC_W-1:0] factor_q;
	logic [FAC_W-1:0] power_q;
	logic [EXP_W-1:0] expo_q;

	spps_sieve #(.DEPTH(MEM_DEPTH)) u_sieve (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_data (rd_data),
		.req     (sieve_req),
		.done    (done)
	);

	spps_mem #(.DEPTH(MEM_DEPTH)) u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign q_oor    = ({1'b0, query.query_number} >= limit_q)
		|| (32'(query.query_number) >= TABLE_W);
	assign load_out = q_s1 && (!out_valid_q || result.ready);
	assign in_ready = done && (!q_s1 || load_out);
	assign q_acc    = query.valid && in_ready;

	assign query.ready = in_ready;

	always_comb begin
		if (done) begin
			mem_req.rd_en   = q_acc && !q_oor;
			mem_req.rd_addr = query.query_number;
			mem_req.wr_en   = 1'b0;
			mem_req.wr_addr = '0;
			mem_req.wr_data = '0;
		end else begin
			mem_req = sieve_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RST;
			q_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			q_s1        <= q_acc || (q_s1 && !load_out);
			out_valid_q <= load_out || (out_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (q_acc) begin
			n_s1   <= query.query_number;
			oor_s1 <= q_oor;
		end
		if (load_out) begin
			oor_q <= oor_s1;
			if (oor_s1) begin
				prime_q  <= 1'b0;
				factor_q <= '0;
				power_q  <= '0;
				expo_q   <= '0;
			end else if (rd_data.comp) begin
				prime_q  <= 1'b0;
				factor_q <= rd_data.factor;
				power_q  <= rd_data.power;
				expo_q   <= rd_data.expo;
			end else begin
				// unmarked entries are primes and carry no stored factor
				prime_q  <= 1'b1;
				factor_q <= FAC_W'(n_s1);
				power_q  <= FAC_W'(n_s1);
				expo_q   <= EXP_W'(1);
			end
		end
	end

	assign result.valid           = out_valid_q;
	assign result.out_of_range    = oor_q;
	assign result.is_prime        = prime_q;
	assign result.smallest_factor = factor_q;
	assign result.factor_power    = power_q;
	assign result.multiplicity    = expo_q;

	`ASSERT_IMPL(a_query_after_build, q_s1, done, "query in flight during build")
	`ASSERT_NEXT(a_pend_hold, q_s1 && !load_out, q_s1, "pending query dropped")
	`ASSERT_IMPL(a_oor_zero, result.valid && result.out_of_range,
		!result.is_prime && result.smallest_factor == '0 && result.multiplicity == '0,
		"out of range result not zero")
endmodule
`default_nettype wire
